### rtl/core/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the source text lexer
// Token kinds, lexer modes and the token record passed front to back.
// ----------------------------------------------------------------------------
package stl_pkg;

	localparam int KEYWORD_BYTES_DEF = 6;
	localparam int LINE_MAX = 1048575;
	localparam int COL_MAX  = 65535;

	typedef enum logic [5:0] {
		K_INT = 6'd0, K_BOOL = 6'd1, K_IDENT = 6'd2,
		K_IF = 6'd3, K_ELSE = 6'd4, K_KINT = 6'd5, K_VOID = 6'd6, K_KBOOL = 6'd7,
		K_DEF = 6'd8, K_WHILE = 6'd9, K_DO = 6'd10, K_FOR = 6'd11, K_TO = 6'd12,
		K_RETURN = 6'd13, K_ALLOC = 6'd14, K_FREE = 6'd15, K_MATCH = 6'd16,
		K_OWN = 6'd17, K_REF = 6'd18, K_PRINT = 6'd19,
		K_PLUS = 6'd20, K_MINUS = 6'd21, K_STAR = 6'd22, K_SLASH = 6'd23,
		K_EQ = 6'd24, K_EQEQ = 6'd25, K_NE = 6'd26, K_LT = 6'd27, K_GT = 6'd28,
		K_LE = 6'd29, K_GE = 6'd30, K_NOT = 6'd31, K_AND = 6'd32, K_OR = 6'd33,
		K_SEMI = 6'd34, K_COLON = 6'd35, K_LPAREN = 6'd36, K_RPAREN = 6'd37,
		K_LBRACE = 6'd38, K_RBRACE = 6'd39, K_UNDER = 6'd40, K_COMMA = 6'd41,
		K_QUEST = 6'd42, K_EOF = 6'd43, K_ERROR = 6'd44
	} kind_t;

	typedef enum logic [3:0] {
		M_IDLE, M_NUMBER, M_WORD, M_SLASH, M_EQ, M_BANG, M_LT, M_GT,
		M_AMP, M_BAR, M_LCOMMENT, M_BCOMMENT, M_BSTAR
	} mode_t;

	typedef enum logic [1:0] {
		E_NONE = 2'd0, E_AMP = 2'd1, E_BAR = 2'd2, E_BYTE = 2'd3
	} err_t;

	// one token, as the back end emits it
	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic [19:0] line;
		logic [15:0] col;
		logic [15:0] wlen;
		err_t        err;
		logic [7:0]  bad;
		logic        last;
	} tok_t;

	// per-byte request: up to two tokens
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       t0;
		tok_t       t1;
	} req_t;

	localparam int REQ_W = $bits(req_t);

endpackage

### rtl/core/stl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_front: byte classifier and lexer state
// Takes one byte per cycle while take is high, updates the lexer state
// and builds the tokens that byte finishes.
// ----------------------------------------------------------------------------
module stl_front
	import stl_pkg::*;
#(
	parameter int KEYWORD_BYTES = KEYWORD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output req_t       req
);

	localparam int WB = 8 * KEYWORD_BYTES;

	mode_t       mode_q;
	logic [31:0] acc_q;
	logic [WB-1:0] wbuf_q;
	logic [15:0] wcnt_q;
	logic [15:0] start_q;
	logic [19:0] line_q;
	logic [15:0] col_q;

	mode_t       mode_d;
	logic [31:0] acc_d;
	logic [WB-1:0] wbuf_d;
	logic [15:0] wcnt_d;
	logic [15:0] start_d;

	logic [7:0] b;
	logic is_dig, is_let, handled, is_ws;
	tok_t pend, tnew, tcmb, teof;
	logic pend_v, tnew_v, tcmb_v;
	kind_t word_kind;
	logic [31:0] word_val;
	logic [31:0] acc_x10;

	assign b = text_byte;
	assign is_dig = (b >= 8'h30) && (b <= 8'h39);
	assign is_let = ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
	assign is_ws = (b == 8'h0a) || (b == 8'h20) || (b == 8'h09) || (b == 8'h0d);
	assign acc_x10 = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0};

	function automatic logic [WB-1:0] pk(input logic [63:0] s);
		return WB'(s);
	endfunction

	// keyword match on the word buffer; words longer than the buffer never match
	always_comb begin
		word_kind = K_IDENT;
		word_val  = '0;
		if (wcnt_q <= 16'(KEYWORD_BYTES)) begin
			case (wbuf_q)
				pk(64'h6669):           word_kind = K_IF;
				pk(64'h65736c65):       word_kind = K_ELSE;
				pk(64'h746e69):         word_kind = K_KINT;
				pk(64'h64696f76):       word_kind = K_VOID;
				pk(64'h6c6f6f62):       word_kind = K_KBOOL;
				pk(64'h666564):         word_kind = K_DEF;
				pk(64'h656c696877):     word_kind = K_WHILE;
				pk(64'h6f64):           word_kind = K_DO;
				pk(64'h726f66):         word_kind = K_FOR;
				pk(64'h6f74):           word_kind = K_TO;
				pk(64'h6e7275746572):   word_kind = K_RETURN;
				pk(64'h636f6c6c61):     word_kind = K_ALLOC;
				pk(64'h65657266):       word_kind = K_FREE;
				pk(64'h686374616d):     word_kind = K_MATCH;
				pk(64'h6e776f):         word_kind = K_OWN;
				pk(64'h666572):         word_kind = K_REF;
				pk(64'h746e697270):     word_kind = K_PRINT;
				pk(64'h65757274): begin
					word_kind = K_BOOL;
					word_val  = 32'd1;
				end
				pk(64'h65736c6166):     word_kind = K_BOOL;
				default:                word_kind = K_IDENT;
			endcase
		end
	end

	// token the pending mode would give if flushed now
	always_comb begin
		pend   = '0;
		pend.line = line_q;
		pend.col  = start_q;
		pend_v = 1'b1;
		case (mode_q)
			M_NUMBER: begin
				pend.kind  = K_INT;
				pend.value = acc_q;
			end
			M_WORD: begin
				pend.kind  = word_kind;
				pend.value = word_val;
				if (word_kind == K_IDENT) pend.wlen = wcnt_q;
			end
			M_SLASH: pend.kind = K_SLASH;
			M_EQ:    pend.kind = K_EQ;
			M_BANG:  pend.kind = K_NOT;
			M_LT:    pend.kind = K_LT;
			M_GT:    pend.kind = K_GT;
			M_AMP: begin
				pend.kind = K_ERROR;
				pend.err  = E_AMP;
			end
			M_BAR: begin
				pend.kind = K_ERROR;
				pend.err  = E_BAR;
			end
			default: pend_v = 1'b0;
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		acc_d   = acc_q;
		wbuf_d  = wbuf_q;
		wcnt_d  = wcnt_q;
		start_d = start_q;
		handled = 1'b0;
		tcmb    = '0;
		tcmb.line = line_q;
		tcmb.col  = start_q;
		tcmb_v  = 1'b0;
		tnew    = '0;
		tnew.line = line_q;
		tnew.col  = col_q;
		tnew_v  = 1'b0;

		case (mode_q)
			M_NUMBER: if (is_dig) begin
				acc_d = acc_x10 + {28'd0, b[3:0]};
				handled = 1'b1;
			end
			M_WORD: if (is_let || is_dig) begin
				for (int i = 0; i < KEYWORD_BYTES; i++)
					if (wcnt_q == 16'(i)) wbuf_d[8*i +: 8] = b;
				if (wcnt_q != 16'hffff) wcnt_d = wcnt_q + 16'd1;
				handled = 1'b1;
			end
			M_SLASH: begin
				if (b == "/") begin
					mode_d = M_LCOMMENT;
					handled = 1'b1;
				end else if (b == "*") begin
					mode_d = M_BCOMMENT;
					handled = 1'b1;
				end
			end
			M_EQ, M_BANG, M_LT, M_GT: if (b == "=") begin
				case (mode_q)
					M_EQ:    tcmb.kind = K_EQEQ;
					M_BANG:  tcmb.kind = K_NE;
					M_LT:    tcmb.kind = K_LE;
					default: tcmb.kind = K_GE;
				endcase
				tcmb_v = 1'b1;
				mode_d = M_IDLE;
				handled = 1'b1;
			end
			M_AMP: if (b == "&") begin
				tcmb.kind = K_AND;
				tcmb_v = 1'b1;
				mode_d = M_IDLE;
				handled = 1'b1;
			end
			M_BAR: if (b == "|") begin
				tcmb.kind = K_OR;
				tcmb_v = 1'b1;
				mode_d = M_IDLE;
				handled = 1'b1;
			end
			M_LCOMMENT: begin
				if (b == 8'h0a) mode_d = M_IDLE;
				else handled = 1'b1;
			end
			M_BCOMMENT: begin
				if (b == "*") mode_d = M_BSTAR;
				handled = 1'b1;
			end
			M_BSTAR: begin
				if (b == "/") mode_d = M_IDLE;
				else if (b != "*") mode_d = M_BCOMMENT;
				handled = 1'b1;
			end
			default: mode_d = M_IDLE;
		endcase

		if (!handled) begin
			mode_d  = M_IDLE;
			start_d = col_q;
			if (is_ws) begin
				mode_d = M_IDLE;
			end else if (is_dig) begin
				mode_d = M_NUMBER;
				acc_d  = {28'd0, b[3:0]};
			end else if (is_let) begin
				mode_d = M_WORD;
				wbuf_d = WB'(b);
				wcnt_d = 16'd1;
			end else begin
				tnew_v = 1'b1;
				case (b)
					"/": begin mode_d = M_SLASH; tnew_v = 1'b0; end
					"=": begin mode_d = M_EQ;    tnew_v = 1'b0; end
					"!": begin mode_d = M_BANG;  tnew_v = 1'b0; end
					"<": begin mode_d = M_LT;    tnew_v = 1'b0; end
					">": begin mode_d = M_GT;    tnew_v = 1'b0; end
					"&": begin mode_d = M_AMP;   tnew_v = 1'b0; end
					"|": begin mode_d = M_BAR;   tnew_v = 1'b0; end
					"{": tnew.kind = K_LBRACE;
					"}": tnew.kind = K_RBRACE;
					"(": tnew.kind = K_LPAREN;
					")": tnew.kind = K_RPAREN;
					"+": tnew.kind = K_PLUS;
					"-": tnew.kind = K_MINUS;
					"*": tnew.kind = K_STAR;
					"?": tnew.kind = K_QUEST;
					"_": tnew.kind = K_UNDER;
					";": tnew.kind = K_SEMI;
					":": tnew.kind = K_COLON;
					",": tnew.kind = K_COMMA;
					default: begin
						tnew.kind = K_ERROR;
						tnew.err  = E_BYTE;
						tnew.bad  = b;
					end
				endcase
			end
		end
	end

	// assemble the request
	always_comb begin
		teof = '0;
		teof.kind = K_EOF;
		teof.line = line_q;
		teof.col  = col_q;
		teof.last = 1'b1;
		req = '0;
		if (end_of_text) begin
			if (pend_v) begin
				req.cnt = 2'd2;
				req.t0  = pend;
				req.t1  = teof;
			end else begin
				req.cnt = 2'd1;
				req.t0  = teof;
			end
		end else if (tcmb_v) begin
			req.cnt = 2'd1;
			req.t0  = tcmb;
			req.t0.last = 1'b1;
		end else if (!handled) begin
			if (pend_v && tnew_v) begin
				req.cnt = 2'd2;
				req.t0  = pend;
				req.t1  = tnew;
				req.t1.last = 1'b1;
			end else if (pend_v) begin
				req.cnt = 2'd1;
				req.t0  = pend;
				req.t0.last = 1'b1;
			end else if (tnew_v) begin
				req.cnt = 2'd1;
				req.t0  = tnew;
				req.t0.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			acc_q   <= '0;
			wbuf_q  <= '0;
			wcnt_q  <= '0;
			start_q <= 16'd1;
			line_q  <= 20'd1;
			col_q   <= 16'd1;
		end else if (take) begin
			if (end_of_text) begin
				mode_q  <= M_IDLE;
				acc_q   <= '0;
				wbuf_q  <= '0;
				wcnt_q  <= '0;
				start_q <= 16'd1;
				line_q  <= 20'd1;
				col_q   <= 16'd1;
			end else begin
				mode_q  <= mode_d;
				acc_q   <= acc_d;
				wbuf_q  <= wbuf_d;
				wcnt_q  <= wcnt_d;
				start_q <= start_d;
				if (b == 8'h0a) begin
					if (line_q != 20'(LINE_MAX)) line_q <= line_q + 20'd1;
					col_q <= 16'd1;
				end else if (col_q != 16'(COL_MAX)) begin
					col_q <= col_q + 16'd1;
				end
			end
		end
	end

endmodule

### rtl/core/stl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_queue: request queue between front and back
// Four-entry queue of per-byte token requests.
// ----------------------------------------------------------------------------
module stl_queue
	import stl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t wdata,
	output logic full,
	input  logic pop,
	output logic empty,
	output req_t rdata
);

	req_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full  = cnt_q == 3'd4;
	assign empty = cnt_q == 3'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop)  rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

### rtl/core/stl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_back: token emitter
// Sends the one or two tokens of each request out through an output register.
// ----------------------------------------------------------------------------
module stl_back
	import stl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  req_t rdata,
	output logic pop,
	input  logic out_stall,
	output logic out_valid,
	output tok_t out_tok
);

	logic sel_q;   // second token of the head request
	logic load;
	logic head_ok;

	// empty requests are dropped without output
	assign head_ok = !empty;
	assign load = head_ok && (rdata.cnt != 2'd0) && (!out_valid || !out_stall);
	assign pop  = head_ok && ((rdata.cnt == 2'd0) ||
		(load && (sel_q || rdata.cnt == 2'd1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			sel_q     <= 1'b0;
		end else begin
			if (load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (load) sel_q <= !pop;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_tok <= sel_q ? rdata.t1 : rdata.t0;
	end

endmodule

### rtl/core/source_text_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_lexer: streaming tokenizer, one byte per unstalled cycle
// Front end classifies bytes, a small queue holds token requests, back end
// emits tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries text_byte and end_of_text. A byte
//   is taken on each edge with in_valid high and in_stall low.
//   Output channel out_valid/out_stall carries one token at a time.
//   Each byte yields zero, one or two tokens; last_of_run marks the final
//   token of a byte. end_of_text flushes any pending token, sends EOF and
//   returns the lexer to its reset state.
//   Throughput: one byte per cycle while tokens are drained; a byte that
//   yields two tokens sends them in turn through the single output port.
//   Requests are queued when taken and unloaded into the output register.
//   The four-entry request queue sets how far the input runs ahead of a
//   stalled receiver; once full, in_stall rises.
//   Reset: all lexer state returns to line 1, column 1, no pending token;
//   queue and output register are emptied.
// ----------------------------------------------------------------------------
module source_text_lexer
	import stl_pkg::*;
#(
	parameter int KEYWORD_BYTES = KEYWORD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  kind,
	output logic [31:0] literal_value,
	output logic [19:0] line_number,
	output logic [15:0] column_number,
	output logic [15:0] word_length,
	output logic [1:0]  error_code,
	output logic [7:0]  bad_char,
	output logic        last_of_run
);

	req_t req, rdata;
	logic take, full, empty, pop;
	tok_t tok;

	assign in_stall = full;
	assign take = in_valid && !full;

	stl_front #(.KEYWORD_BYTES(KEYWORD_BYTES)) u_front (
		.clk, .arst_n, .take, .text_byte, .end_of_text, .req
	);

	stl_queue u_queue (
		.clk, .arst_n, .push(take), .wdata(req), .full,
		.pop, .empty, .rdata
	);

	stl_back u_back (
		.clk, .arst_n, .empty, .rdata, .pop, .out_stall,
		.out_valid, .out_tok(tok)
	);

	assign kind          = tok.kind;
	assign literal_value = tok.value;
	assign line_number   = tok.line;
	assign column_number = tok.col;
	assign word_length   = tok.wlen;
	assign error_code    = tok.err;
	assign bad_char      = tok.bad;
	assign last_of_run   = tok.last;

endmodule

### rtl/core/stl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_checker: port-level checks for the lexer
// Watches the top-level ports over time.
// ----------------------------------------------------------------------------
module stl_checker
	import stl_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [5:0] kind,
	input logic [1:0] error_code,
	input logic       last_of_run,
	input logic [15:0] word_length
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind))
		else $error("token changed under stall");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_EOF |-> last_of_run)
		else $error("EOF not last of run");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != E_NONE |-> kind == K_ERROR)
		else $error("error code on non-error token");

	a_wlen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_length != 16'd0 |-> kind == K_IDENT)
		else $error("length on non-identifier");

endmodule

bind source_text_lexer stl_checker u_stl_checker (
	.clk, .arst_n, .out_valid, .out_stall, .kind, .error_code,
	.last_of_run, .word_length
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for source_text_lexer
// Feeds byte streams (directed rows, then random program-like text with noise),
// predicts the token stream in the bench and compares every emitted token.
// ----------------------------------------------------------------------------
module tb;
	import stl_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [31:0] value;
		logic [19:0] line;
		logic [15:0] col;
		logic [15:0] wlen;
		err_t        err;
		logic [7:0]  bad;
		logic        last;
	} token_s;

	typedef struct {
		logic [7:0] b;
		logic       eot;
		logic       typed;   // expected token typed in below
		kind_t      kind;
		err_t       err;
	} row_s;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = 8'd0;
	logic        end_of_text = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  kind;
	logic [31:0] literal_value;
	logic [19:0] line_number;
	logic [15:0] column_number;
	logic [15:0] word_length;
	logic [1:0]  error_code;
	logic [7:0]  bad_char;
	logic        last_of_run;

	source_text_lexer i_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	mode_t       lx_mode;
	logic [31:0] lx_num;
	logic [47:0] lx_word;
	logic [15:0] lx_wcount;
	logic [15:0] lx_tcol;
	logic [19:0] lx_line;
	logic [15:0] lx_col;

	token_s pending_tokens[$];
	token_s step_out[$];
	int     n_fail = 0;
	int     n_tokens = 0;
	int     n_bytes = 0;
	int     idle_cycles = 0;
	logic   done_feeding = 1'b0;

	function automatic void lexer_reset();
		lx_mode = M_IDLE; lx_num = '0; lx_word = '0; lx_wcount = '0;
		lx_tcol = 16'd1; lx_line = 20'd1; lx_col = 16'd1;
	endfunction

	function automatic void put_token(kind_t k, logic [31:0] v, logic [15:0] c,
			logic [15:0] wl, err_t e, logic [7:0] bc);
		token_s t;
		t.kind = k; t.value = v; t.line = lx_line; t.col = c; t.wlen = wl;
		t.err = e; t.bad = bc; t.last = 1'b0;
		step_out.push_back(t);
	endfunction

	function automatic logic [47:0] pack_word(string s);
		logic [47:0] p;
		p = '0;
		for (int i = 0; i < s.len(); i++) p[8*i +: 8] = s[i];
		return p;
	endfunction

	function automatic void word_token();
		string names[19];
		kind_t kinds[19];
		names = '{"if", "else", "int", "void", "bool", "def", "while", "do", "for",
			"to", "return", "alloc", "free", "match", "own", "ref", "print",
			"true", "false"};
		kinds = '{K_IF, K_ELSE, K_KINT, K_VOID, K_KBOOL, K_DEF, K_WHILE, K_DO,
			K_FOR, K_TO, K_RETURN, K_ALLOC, K_FREE, K_MATCH, K_OWN, K_REF,
			K_PRINT, K_BOOL, K_BOOL};
		for (int k = 0; k < 19; k++)
			if (lx_wcount == names[k].len() && lx_word == pack_word(names[k])) begin
				put_token(kinds[k], (k == 17) ? 32'd1 : 32'd0, lx_tcol, '0, E_NONE, '0);
				return;
			end
		put_token(K_IDENT, '0, lx_tcol, lx_wcount, E_NONE, '0);
	endfunction

	function automatic void flush_token();
		case (lx_mode)
			M_NUMBER: put_token(K_INT, lx_num, lx_tcol, '0, E_NONE, '0);
			M_WORD:   word_token();
			M_SLASH:  put_token(K_SLASH, '0, lx_tcol, '0, E_NONE, '0);
			M_EQ:     put_token(K_EQ, '0, lx_tcol, '0, E_NONE, '0);
			M_BANG:   put_token(K_NOT, '0, lx_tcol, '0, E_NONE, '0);
			M_LT:     put_token(K_LT, '0, lx_tcol, '0, E_NONE, '0);
			M_GT:     put_token(K_GT, '0, lx_tcol, '0, E_NONE, '0);
			M_AMP:    put_token(K_ERROR, '0, lx_tcol, '0, E_AMP, '0);
			M_BAR:    put_token(K_ERROR, '0, lx_tcol, '0, E_BAR, '0);
			default: ;
		endcase
		lx_mode = M_IDLE;
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_letter(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic void begin_token(logic [7:0] b);
		kind_t k;
		logic  one;
		lx_tcol = lx_col;
		one = 1'b1;
		if (b == 8'd10 || b == " " || b == 8'd9 || b == 8'd13) return;
		if (is_digit(b)) begin
			lx_mode = M_NUMBER; lx_num = 32'(b - "0"); return;
		end
		if (is_letter(b)) begin
			lx_mode = M_WORD; lx_word = 48'(b); lx_wcount = 16'd1; return;
		end
		case (b)
			"/": begin lx_mode = M_SLASH; return; end
			"=": begin lx_mode = M_EQ; return; end
			"!": begin lx_mode = M_BANG; return; end
			"<": begin lx_mode = M_LT; return; end
			">": begin lx_mode = M_GT; return; end
			"&": begin lx_mode = M_AMP; return; end
			"|": begin lx_mode = M_BAR; return; end
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"?": k = K_QUEST;
			"_": k = K_UNDER;
			";": k = K_SEMI;
			":": k = K_COLON;
			",": k = K_COMMA;
			default: one = 1'b0;
		endcase
		if (one) put_token(k, '0, lx_col, '0, E_NONE, '0);
		else put_token(K_ERROR, '0, lx_col, '0, E_BYTE, b);
	endfunction

	// advance the predictor by one request and queue the tokens it yields
	function automatic void lex_byte(logic [7:0] b, logic eot);
		logic taken;
		step_out.delete();
		taken = 1'b0;
		if (eot) begin
			flush_token();
			put_token(K_EOF, '0, lx_col, '0, E_NONE, '0);
			lexer_reset();
		end else begin
			case (lx_mode)
				M_NUMBER: if (is_digit(b)) begin
					lx_num = lx_num * 32'd10 + 32'(b - "0"); taken = 1'b1;
				end
				M_WORD: if (is_letter(b) || is_digit(b)) begin
					if (lx_wcount < 16'd6) lx_word[8*lx_wcount +: 8] = b;
					if (lx_wcount != 16'hFFFF) lx_wcount++;
					taken = 1'b1;
				end
				M_SLASH:
					if (b == "/") begin lx_mode = M_LCOMMENT; taken = 1'b1; end
					else if (b == "*") begin lx_mode = M_BCOMMENT; taken = 1'b1; end
				M_EQ, M_BANG, M_LT, M_GT: if (b == "=") begin
					put_token(lx_mode == M_EQ ? K_EQEQ : lx_mode == M_BANG ? K_NE :
						lx_mode == M_LT ? K_LE : K_GE, '0, lx_tcol, '0, E_NONE, '0);
					lx_mode = M_IDLE; taken = 1'b1;
				end
				M_AMP: if (b == "&") begin
					put_token(K_AND, '0, lx_tcol, '0, E_NONE, '0);
					lx_mode = M_IDLE; taken = 1'b1;
				end
				M_BAR: if (b == "|") begin
					put_token(K_OR, '0, lx_tcol, '0, E_NONE, '0);
					lx_mode = M_IDLE; taken = 1'b1;
				end
				M_LCOMMENT:
					if (b == 8'd10) lx_mode = M_IDLE;
					else taken = 1'b1;
				M_BCOMMENT: begin
					if (b == "*") lx_mode = M_BSTAR;
					taken = 1'b1;
				end
				M_BSTAR: begin
					if (b == "/") lx_mode = M_IDLE;
					else if (b != "*") lx_mode = M_BCOMMENT;
					taken = 1'b1;
				end
				default: lx_mode = M_IDLE;
			endcase
			if (!taken) begin
				flush_token();
				begin_token(b);
			end
			if (b == 8'd10) begin
				if (lx_line != 20'(LINE_MAX)) lx_line++;
				lx_col = 16'd1;
			end else if (lx_col != 16'(COL_MAX)) begin
				lx_col++;
			end
		end
		if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
		foreach (step_out[i]) pending_tokens.push_back(step_out[i]);
	endfunction

	// in_valid drops only for a gap before the byte, so it is assigned once per edge
	task automatic send_byte(logic [7:0] b, logic eot);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		do @(posedge clk); while (in_stall);
		lex_byte(b, eot);
		n_bytes++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_tokens.size() > 0) @(posedge clk);
	endtask

	// receiver: random stall per token, compare against the predicted stream
	initial begin
		int hold;
		token_s e;
		forever begin
			hold = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0) hold = 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			n_tokens++;
			if (pending_tokens.size() == 0) begin
				$error("token with nothing expected: kind %0d", kind);
				n_fail++;
			end else begin
				e = pending_tokens.pop_front();
				if (kind != e.kind) begin
					$error("kind exp %0d got %0d", e.kind, kind); n_fail++; end
				if (literal_value != e.value) begin
					$error("literal_value exp %0d got %0d", e.value, literal_value);
					n_fail++; end
				if (line_number != e.line) begin
					$error("line_number exp %0d got %0d", e.line, line_number); n_fail++; end
				if (column_number != e.col) begin
					$error("column_number exp %0d got %0d", e.col, column_number);
					n_fail++; end
				if (word_length != e.wlen) begin
					$error("word_length exp %0d got %0d", e.wlen, word_length); n_fail++; end
				if (error_code != e.err) begin
					$error("error_code exp %0d got %0d", e.err, error_code); n_fail++; end
				if (bad_char != e.bad) begin
					$error("bad_char exp %0d got %0d", e.bad, bad_char); n_fail++; end
				if (last_of_run != e.last) begin
					$error("last_of_run exp %0d got %0d", e.last, last_of_run); n_fail++; end
			end
		end
	end

	// watchdog: cycles with no accepted request on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || done_feeding)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("timeout after %0d bytes", n_bytes);
			$display("Some tests failed");
			$finish;
		end
	end

	string frags[] = '{"if ", "else", "int ", "void ", "bool ", "def ", "while",
		"do", "for ", "to ", "return", "alloc", "free ", "match", "own", "ref ",
		"print", "true", "false", "x1", "abcdefgh ", "retur", "returns ", "4294967296",
		"123", "0", "== ", "!= ", "<= ", ">= ", "= ", "!", "<", ">", "&&", "||",
		"& ", "| ", "+", "-", "*", "/", "{", "}", "(", ")", ";", ":", ",", "?",
		"_", " ", "\t", "\r", "\n", "// note\n", "/* c ** */", "/**/", "a.b"};

	row_s dir_rows[$];

	initial begin
		row_s r;
		logic [7:0] b;
		lexer_reset();
		// directed rows; typed rows are checked against the predictor too
		dir_rows = '{
			'{8'd0,   1'b0, 1'b1, K_ERROR, E_BYTE},
			'{8'd255, 1'b0, 1'b1, K_ERROR, E_BYTE},
			'{8'd128, 1'b0, 1'b1, K_ERROR, E_BYTE},
			'{"&",    1'b0, 1'b0, K_INT, E_NONE},
			'{" ",    1'b0, 1'b1, K_ERROR, E_AMP},
			'{"|",    1'b0, 1'b0, K_INT, E_NONE},
			'{8'd127, 1'b0, 1'b0, K_INT, E_NONE},
			'{"9",    1'b0, 1'b0, K_INT, E_NONE},
			'{"&",    1'b0, 1'b0, K_INT, E_NONE},
			'{8'd0,   1'b1, 1'b0, K_INT, E_NONE},
			'{"Z",    1'b0, 1'b0, K_INT, E_NONE},
			'{"|",    1'b0, 1'b0, K_INT, E_NONE},
			'{8'hAA,  1'b1, 1'b0, K_INT, E_NONE},
			'{"/",    1'b0, 1'b0, K_INT, E_NONE},
			'{"*",    1'b0, 1'b0, K_INT, E_NONE},
			'{8'h55,  1'b1, 1'b1, K_EOF, E_NONE}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			send_byte(r.b, r.eot);
			if (r.typed) begin
				token_s t;
				t = pending_tokens[pending_tokens.size()-1];
				if (t.kind != r.kind || t.err != r.err) begin
					$error("kind exp %0d got %0d", r.kind, t.kind); n_fail++;
				end
			end
		end
		// every operator, keyword and comment form once
		foreach (frags[i]) send_text(frags[i]);
		send_byte(8'd0, 1'b1);
		wait_drained();

		// hold off until the lexer has drained everything
		repeat (10) @(posedge clk);

		while (n_bytes < 1400) begin
			if ($urandom_range(0, 9) < 8) begin
				send_text(frags[$urandom_range(0, frags.size()-1)]);
				if ($urandom_range(0, 1)) send_byte(" ", 1'b0);
			end else begin
				b = 8'($urandom_range(0, 255));
				send_byte(b, 1'b0);
			end
			if ($urandom_range(0, 60) == 0) send_byte(8'($urandom), 1'b1);
		end
		// one long identifier to push word_length
		send_byte("q", 1'b0);
		repeat (300) send_byte("7", 1'b0);
		send_byte(8'($urandom), 1'b1);
		done_feeding <= 1'b1;
		fork
			wait_drained();
			begin
				repeat (20000) @(posedge clk);
				$display("timeout draining tokens");
				$display("Some tests failed");
				$finish;
			end
		join_any
		repeat (10) @(posedge clk);
		$display("Lexed %0d bytes into %0d tokens: keywords, operators, comments,",
			n_bytes, n_tokens);
		$display("literals, lone &/|, unknown bytes and end-of-text flushes.");
		if (n_fail == 0 && pending_tokens.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
rtl/core/stl_pkg.sv
rtl/core/stl_front.sv
rtl/core/stl_queue.sv
rtl/core/stl_back.sv
rtl/core/source_text_lexer.sv
rtl/core/stl_checker.sv
tb/sv/tb.sv
